// ===== rtl/core/egw_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package egw_pkg;

    localparam int FLAG_W = 32;
    localparam int TASK_W = 4;
    localparam int PRIO_W = 8;
    localparam int ACT_W  = 2;
    localparam int STAT_W = 3;

    typedef enum logic [ACT_W-1:0] {
        ACT_SET   = 2'd0,
        ACT_CLEAR = 2'd1,
        ACT_WAIT  = 2'd2,
        ACT_READ  = 2'd3
    } action_t;

    typedef enum logic [STAT_W-1:0] {
        ST_DONE    = 3'd0,
        ST_AT_ONCE = 3'd1,
        ST_BLOCKED = 3'd2,
        ST_WOKEN   = 3'd3,
        ST_FULL    = 3'd4
    } status_t;

    // One blocked waiter
    typedef struct packed {
        logic [TASK_W-1:0] task_id;
        logic [PRIO_W-1:0] prio;
        logic [FLAG_W-1:0] mask;
        logic              wait_all;
        logic              clear_on_wake;
    } waiter_t;

    // Controller to datapath
    typedef struct packed {
        logic accept;
        logic keep;
        logic wake;
        logic done;
    } egw_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic in_set;
        logic walk_end;
        logic hit;
        logic out_free;
    } egw_sts_t;

    function automatic logic cond_holds(input logic [FLAG_W-1:0] flags,
                                        input logic [FLAG_W-1:0] mask,
                                        input logic              all_mode);
        logic result;
        if (all_mode)
            result = ((flags & mask) == mask);
        else
            result = ((flags & mask) != '0);
        return result;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/egw_chan_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface egw_in_if;
    logic                      valid;
    logic                      ready;
    logic [1:0]                action;
    logic [egw_pkg::FLAG_W-1:0] flag_bits;
    logic [egw_pkg::TASK_W-1:0] task_id;
    logic [egw_pkg::PRIO_W-1:0] priority_req;
    logic                      wait_all;
    logic                      clear_on_wake;

    modport source (output valid, action, flag_bits, task_id, priority_req,
                    wait_all, clear_on_wake, input ready);
    modport sink (input valid, action, flag_bits, task_id, priority_req,
                  wait_all, clear_on_wake, output ready);
endinterface

interface egw_out_if;
    logic                      valid;
    logic                      ready;
    logic [2:0]                status;
    logic [egw_pkg::TASK_W-1:0] woken_task;
    logic [egw_pkg::FLAG_W-1:0] observed_flags;
    logic [egw_pkg::FLAG_W-1:0] current_flags;
    logic                      last;

    modport source (output valid, status, woken_task, observed_flags,
                    current_flags, last, input ready);
    modport sink (input valid, status, woken_task, observed_flags,
                  current_flags, last, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/event_flag_group_waiters.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Event flag group with a priority-ordered table of up to WAITER_SLOTS blocked
// waiters. Clear, read and wait items each give one result.
// A set item is accepted, then walks the queued waiters one per cycle (a satisfied
// waiter only when the output register is free), then gives the final result,
// so it gives one woken result per satisfied waiter and a final done result;
// each walk step depends on the flag word left by the previous step's
// auto-clear. A stalled output holds the walk at a satisfied waiter or at its
// end. A new item is taken only when the block is not walking and the output
// register is free or being taken.
module event_flag_group_waiters #(
    parameter int WAITER_SLOTS = 12
) (
    input wire logic clk,
    input wire logic rst_n,
    egw_in_if.sink   in_ch,
    egw_out_if.source out_ch
);
    import egw_pkg::*;

    egw_cmd_t cmd;
    egw_sts_t sts;
    logic [$clog2(WAITER_SLOTS+1)-1:0] waiter_count;

    egw_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    egw_dp #(
        .WAITER_SLOTS (WAITER_SLOTS)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_action        (in_ch.action),
        .in_flag_bits     (in_ch.flag_bits),
        .in_task_id       (in_ch.task_id),
        .in_priority      (in_ch.priority_req),
        .in_wait_all      (in_ch.wait_all),
        .in_clear_on_wake (in_ch.clear_on_wake),
        .cmd              (cmd),
        .sts              (sts),
        .waiter_count     (waiter_count),
        .out_valid        (out_ch.valid),
        .out_ready        (out_ch.ready),
        .out_status       (out_ch.status),
        .out_task         (out_ch.woken_task),
        .out_observed     (out_ch.observed_flags),
        .out_current      (out_ch.current_flags),
        .out_last         (out_ch.last)
    );

    // A result is loaded only into a free output register
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.wake || cmd.done) |-> sts.out_free)
        else $error("result loaded over a pending result");

    // The table never holds more than its slots
    assert property (@(posedge clk) disable iff (!rst_n)
        waiter_count <= ($clog2(WAITER_SLOTS+1))'(WAITER_SLOTS))
        else $error("waiter count overflow");

    // Closing a walk presents the final result next
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.done |=> (out_ch.valid && out_ch.last))
        else $error("walk closed without a final result");

endmodule

`default_nettype wire

// ===== rtl/core/egw_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module egw_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire egw_pkg::egw_sts_t sts,
    output egw_pkg::egw_cmd_t      cmd
);
    import egw_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_WALK
    } state_t;

    state_t state_reg, state_next;

    // Decide the next step from the walk status
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready   = sts.out_free;
                cmd.accept = in_valid && sts.out_free;
                if (cmd.accept && sts.in_set)
                    state_next = S_WALK;
            end
            S_WALK:
            begin
                if (sts.walk_end)
                begin
                    cmd.done = sts.out_free;
                    if (sts.out_free)
                        state_next = S_IDLE;
                end
                else if (sts.hit)
                    cmd.wake = sts.out_free;
                else
                    cmd.keep = 1'b1;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

`default_nettype wire

// ===== rtl/core/egw_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none

module egw_dp #(
    parameter int WAITER_SLOTS = 12
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic [1:0]                 in_action,
    input  wire logic [egw_pkg::FLAG_W-1:0] in_flag_bits,
    input  wire logic [egw_pkg::TASK_W-1:0] in_task_id,
    input  wire logic [egw_pkg::PRIO_W-1:0] in_priority,
    input  wire logic                       in_wait_all,
    input  wire logic                       in_clear_on_wake,
    input  wire egw_pkg::egw_cmd_t          cmd,
    output egw_pkg::egw_sts_t               sts,
    output logic [$clog2(WAITER_SLOTS+1)-1:0] waiter_count,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic [egw_pkg::STAT_W-1:0]      out_status,
    output logic [egw_pkg::TASK_W-1:0]      out_task,
    output logic [egw_pkg::FLAG_W-1:0]      out_observed,
    output logic [egw_pkg::FLAG_W-1:0]      out_current,
    output logic                            out_last
);
    import egw_pkg::*;

    localparam int CW = $clog2(WAITER_SLOTS + 1);
    localparam int IW = (WAITER_SLOTS > 1) ? $clog2(WAITER_SLOTS) : 1;

    logic [FLAG_W-1:0] flag_reg, flag_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [CW-1:0]     rd_reg, rd_next;
    logic [CW-1:0]     wr_reg, wr_next;
    waiter_t           entry_reg [WAITER_SLOTS];
    waiter_t           entry_next [WAITER_SLOTS];

    logic              out_valid_reg, out_valid_next;
    logic [STAT_W-1:0] out_status_reg, out_status_next;
    logic [TASK_W-1:0] out_task_reg, out_task_next;
    logic [FLAG_W-1:0] out_obs_reg, out_obs_next;
    logic [FLAG_W-1:0] out_cur_reg, out_cur_next;
    logic              out_last_reg, out_last_next;

    waiter_t           cur_entry;
    waiter_t           new_entry;
    logic [CW-1:0]     ins_pos;
    logic              out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign cur_entry = entry_reg[rd_reg[IW-1:0]];

    assign sts.in_set   = (in_action == ACT_SET);
    assign sts.walk_end = (rd_reg == count_reg);
    assign sts.hit      = cond_holds(flag_reg, cur_entry.mask, cur_entry.wait_all);
    assign sts.out_free = out_free;

    assign new_entry = '{task_id: in_task_id, prio: in_priority, mask: in_flag_bits,
                         wait_all: in_wait_all, clear_on_wake: in_clear_on_wake};

    // Count queued waiters that stay ahead of the new one
    always_comb
    begin
        ins_pos = '0;
        for (int i = 0; i < WAITER_SLOTS; i++)
        begin
            if ((CW'(i) < count_reg) && (entry_reg[i].prio <= in_priority))
                ins_pos = ins_pos + 1'b1;
        end
    end

    // Flag word, waiter table and result
    always_comb
    begin
        flag_next       = flag_reg;
        count_next      = count_reg;
        rd_next         = rd_reg;
        wr_next         = wr_reg;
        entry_next      = entry_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_status_next = out_status_reg;
        out_task_next   = out_task_reg;
        out_obs_next    = out_obs_reg;
        out_cur_next    = out_cur_reg;
        out_last_next   = out_last_reg;

        if (cmd.accept)
        begin
            out_status_next = ST_DONE;
            out_task_next   = '0;
            out_obs_next    = '0;
            out_last_next   = 1'b1;
            case (in_action)
                ACT_SET:
                begin
                    flag_next = flag_reg | in_flag_bits;
                    rd_next   = '0;
                    wr_next   = '0;
                end
                ACT_CLEAR:
                begin
                    flag_next      = flag_reg & ~in_flag_bits;
                    out_cur_next   = flag_next;
                    out_valid_next = 1'b1;
                end
                ACT_WAIT:
                begin
                    out_task_next  = in_task_id;
                    out_valid_next = 1'b1;
                    if (cond_holds(flag_reg, in_flag_bits, in_wait_all))
                    begin
                        out_status_next = ST_AT_ONCE;
                        out_obs_next    = flag_reg;
                        if (in_clear_on_wake)
                            flag_next = flag_reg & ~in_flag_bits;
                    end
                    else if (count_reg >= CW'(WAITER_SLOTS))
                        out_status_next = ST_FULL;
                    else
                    begin
                        out_status_next = ST_BLOCKED;
                        count_next      = count_reg + 1'b1;
                        for (int i = 0; i < WAITER_SLOTS; i++)
                        begin
                            if (CW'(i) == ins_pos)
                                entry_next[i] = new_entry;
                            else if (i > 0 && CW'(i) > ins_pos && CW'(i) <= count_reg)
                                entry_next[i] = entry_reg[(i > 0) ? i - 1 : 0];
                        end
                    end
                    out_cur_next = flag_next;
                end
                default:
                begin
                    out_cur_next   = flag_reg;
                    out_valid_next = 1'b1;
                end
            endcase
        end

        // Keep an unsatisfied waiter, compacting toward the front
        if (cmd.keep)
        begin
            entry_next[wr_reg[IW-1:0]] = cur_entry;
            wr_next = wr_reg + 1'b1;
            rd_next = rd_reg + 1'b1;
        end

        // Wake a satisfied waiter and drop it from the table
        if (cmd.wake)
        begin
            if (cur_entry.clear_on_wake)
                flag_next = flag_reg & ~cur_entry.mask;
            rd_next         = rd_reg + 1'b1;
            out_valid_next  = 1'b1;
            out_status_next = ST_WOKEN;
            out_task_next   = cur_entry.task_id;
            out_obs_next    = flag_reg;
            out_cur_next    = flag_next;
            out_last_next   = 1'b0;
        end

        // Close the walk
        if (cmd.done)
        begin
            count_next      = wr_reg;
            out_valid_next  = 1'b1;
            out_status_next = ST_DONE;
            out_task_next   = '0;
            out_obs_next    = '0;
            out_cur_next    = flag_reg;
            out_last_next   = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flag_reg      <= '0;
            count_reg     <= '0;
            rd_reg        <= '0;
            wr_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            flag_reg      <= flag_next;
            count_reg     <= count_next;
            rd_reg        <= rd_next;
            wr_reg        <= wr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg      <= entry_next;
        out_status_reg <= out_status_next;
        out_task_reg   <= out_task_next;
        out_obs_reg    <= out_obs_next;
        out_cur_reg    <= out_cur_next;
        out_last_reg   <= out_last_next;
    end

    assign waiter_count = count_reg;
    assign out_valid    = out_valid_reg;
    assign out_status   = out_status_reg;
    assign out_task     = out_task_reg;
    assign out_observed = out_obs_reg;
    assign out_current  = out_cur_reg;
    assign out_last     = out_last_reg;

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import egw_pkg::*;

    localparam int SLOTS = 12;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int STALL_CYCLES = 400;

    typedef struct packed {
        logic [1:0]        action;
        logic [FLAG_W-1:0] flag_bits;
        logic [TASK_W-1:0] task_id;
        logic [PRIO_W-1:0] priority_req;
        logic              wait_all;
        logic              clear_on_wake;
    } request_t;

    typedef struct packed {
        logic [2:0]        status;
        logic [TASK_W-1:0] woken_task;
        logic [FLAG_W-1:0] observed_flags;
        logic [FLAG_W-1:0] current_flags;
        logic              last;
    } reply_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    egw_in_if  in_ch();
    egw_out_if out_ch();

    event_flag_group_waiters DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    always #6 clk = ~clk;

    // Flag group shadow
    logic [FLAG_W-1:0] shadow_flags;
    logic              shadow_valid [SLOTS];
    logic [TASK_W-1:0] shadow_task [SLOTS];
    logic [PRIO_W-1:0] shadow_prio [SLOTS];
    logic [FLAG_W-1:0] shadow_mask [SLOTS];
    logic              shadow_all [SLOTS];
    logic              shadow_aclr [SLOTS];
    int                shadow_order [SLOTS];
    int                shadow_count;

    request_t pending_items [$];
    reply_t   expected_replies [$];

    int mismatches = 0;
    int sent_count = 0;
    int total_items = 0;
    int send_idle_pct = 19;
    int recv_idle_pct = 55;
    int hold_off;
    bit stall_go = 1'b0;
    bit stall_taken;
    int idle_cycles = 0;
    bit stim_done = 0;

    function automatic logic holds(logic [FLAG_W-1:0] f, logic [FLAG_W-1:0] m, logic a);
        if (a)
            return (f & m) == m;
        return (f & m) != '0;
    endfunction

    function automatic reply_t make_reply(logic [2:0] st, logic [TASK_W-1:0] t,
                                          logic [FLAG_W-1:0] obs, logic lst);
        reply_t r;
        r.status = st;
        r.woken_task = t;
        r.observed_flags = obs;
        r.current_flags = shadow_flags;
        r.last = lst;
        return r;
    endfunction

    // Advance the shadow by one accepted item and queue its replies
    task automatic predict_group(request_t rq);
        int kept;
        int s;
        int pos;
        logic [FLAG_W-1:0] seen;
        kept = 0;
        case (rq.action)
            ACT_SET:
            begin
                shadow_flags = shadow_flags | rq.flag_bits;
                for (int i = 0; i < shadow_count; i++)
                begin
                    s = shadow_order[i];
                    if (shadow_valid[s] && holds(shadow_flags, shadow_mask[s], shadow_all[s]))
                    begin
                        seen = shadow_flags;
                        if (shadow_aclr[s])
                            shadow_flags &= ~shadow_mask[s];
                        shadow_valid[s] = 1'b0;
                        expected_replies.push_back(make_reply(ST_WOKEN, shadow_task[s],
                                                              seen, 1'b0));
                    end
                    else
                    begin
                        shadow_order[kept] = s;
                        kept++;
                    end
                end
                shadow_count = kept;
                expected_replies.push_back(make_reply(ST_DONE, '0, '0, 1'b1));
            end
            ACT_CLEAR:
            begin
                shadow_flags &= ~rq.flag_bits;
                expected_replies.push_back(make_reply(ST_DONE, '0, '0, 1'b1));
            end
            ACT_READ:
                expected_replies.push_back(make_reply(ST_DONE, '0, '0, 1'b1));
            default:
            begin
                if (holds(shadow_flags, rq.flag_bits, rq.wait_all))
                begin
                    seen = shadow_flags;
                    if (rq.clear_on_wake)
                        shadow_flags &= ~rq.flag_bits;
                    expected_replies.push_back(make_reply(ST_AT_ONCE, rq.task_id, seen, 1'b1));
                end
                else
                begin
                    s = SLOTS;
                    for (int i = SLOTS - 1; i >= 0; i--)
                        if (!shadow_valid[i])
                            s = i;
                    if (s >= SLOTS || shadow_count >= SLOTS)
                        expected_replies.push_back(make_reply(ST_FULL, rq.task_id, '0, 1'b1));
                    else
                    begin
                        shadow_valid[s] = 1'b1;
                        shadow_task[s] = rq.task_id;
                        shadow_prio[s] = rq.priority_req;
                        shadow_mask[s] = rq.flag_bits;
                        shadow_all[s] = rq.wait_all;
                        shadow_aclr[s] = rq.clear_on_wake;
                        pos = 0;
                        while (pos < shadow_count &&
                               shadow_prio[shadow_order[pos]] <= rq.priority_req)
                            pos++;
                        for (int j = shadow_count; j > pos; j--)
                            shadow_order[j] = shadow_order[j - 1];
                        shadow_order[pos] = s;
                        shadow_count++;
                        expected_replies.push_back(make_reply(ST_BLOCKED, rq.task_id,
                                                              '0, 1'b1));
                    end
                end
            end
        endcase
    endtask

    function automatic request_t build_item(logic [1:0] act, logic [FLAG_W-1:0] bits,
                                            logic [TASK_W-1:0] t, logic [PRIO_W-1:0] p,
                                            logic all, logic aclr);
        request_t rq;
        rq.action = act;
        rq.flag_bits = bits;
        rq.task_id = t;
        rq.priority_req = p;
        rq.wait_all = all;
        rq.clear_on_wake = aclr;
        return rq;
    endfunction

    // Mostly narrow masks, with some zero and random ones, so waits both block and wake
    function automatic logic [FLAG_W-1:0] sparse_bits();
        logic [FLAG_W-1:0] b;
        case ($urandom_range(0, 3))
            0: b = $urandom();
            1: b = '0;
            default: b = (32'h1 << $urandom_range(0, 31)) | (32'h1 << $urandom_range(0, 31));
        endcase
        return b;
    endfunction

    // Drive input items from the pending queue
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
            in_ch.action <= '0;
            in_ch.flag_bits <= '0;
            in_ch.task_id <= '0;
            in_ch.priority_req <= '0;
            in_ch.wait_all <= 1'b0;
            in_ch.clear_on_wake <= 1'b0;
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                predict_group(build_item(in_ch.action, in_ch.flag_bits, in_ch.task_id,
                                         in_ch.priority_req, in_ch.wait_all,
                                         in_ch.clear_on_wake));
                sent_count <= sent_count + 1;
            end
            if (!in_ch.valid || in_ch.ready)
            begin
                if (pending_items.size() > 0 && $urandom_range(1, 100) > send_idle_pct)
                begin
                    request_t rq;
                    rq = pending_items.pop_front();
                    in_ch.valid <= 1'b1;
                    in_ch.action <= rq.action;
                    in_ch.flag_bits <= rq.flag_bits;
                    in_ch.task_id <= rq.task_id;
                    in_ch.priority_req <= rq.priority_req;
                    in_ch.wait_all <= rq.wait_all;
                    in_ch.clear_on_wake <= rq.clear_on_wake;
                end
                else
                    in_ch.valid <= 1'b0;
            end
        end
    end

    // Count down the long receiver stall once it is requested
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_off <= 0;
            stall_taken <= 1'b0;
        end
        else if (stall_go && !stall_taken)
        begin
            hold_off <= STALL_CYCLES;
            stall_taken <= 1'b1;
        end
        else if (hold_off > 0)
            hold_off <= hold_off - 1;
    end

    // Receive and check result items
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                reply_t got;
                reply_t want;
                got.status = out_ch.status;
                got.woken_task = out_ch.woken_task;
                got.observed_flags = out_ch.observed_flags;
                got.current_flags = out_ch.current_flags;
                got.last = out_ch.last;
                if (expected_replies.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result item %h", got);
                end
                else
                begin
                    want = expected_replies.pop_front();
                    if (got.status !== want.status || got.woken_task !== want.woken_task ||
                        got.observed_flags !== want.observed_flags ||
                        got.current_flags !== want.current_flags || got.last !== want.last)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: exp %0d %0d %h %h %0d got %0d %0d %h %h %0d",
                                     want.status, want.woken_task, want.observed_flags,
                                     want.current_flags, want.last, got.status,
                                     got.woken_task, got.observed_flags, got.current_flags,
                                     got.last);
                    end
                end
            end
            if (hold_off > 0)
                out_ch.ready <= 1'b0;
            else
                out_ch.ready <= ($urandom_range(1, 100) > recv_idle_pct);
        end
    end

    // Watchdog on cycles without any accepted item
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic wait_drained();
        while (sent_count < total_items || expected_replies.size() > 0)
            @(posedge clk);
    endtask

    initial
    begin
        request_t rq;
        shadow_flags = '0;
        shadow_count = 0;
        for (int i = 0; i < SLOTS; i++)
            shadow_valid[i] = 1'b0;

        // Directed: extremes, every action, empty masks, full table, equal priorities
        pending_items.push_back(build_item(ACT_READ, '0, '0, '0, 0, 0));
        pending_items.push_back(build_item(ACT_SET, '1, '1, '1, 1, 1));
        pending_items.push_back(build_item(ACT_WAIT, 32'h8000_0001, 4'd3, 8'd0, 1, 1));
        pending_items.push_back(build_item(ACT_WAIT, '1, 4'd15, 8'd255, 0, 0));
        pending_items.push_back(build_item(ACT_CLEAR, '1, '0, '0, 0, 0));
        pending_items.push_back(build_item(ACT_WAIT, '0, 4'd1, 8'd5, 1, 0));
        pending_items.push_back(build_item(ACT_WAIT, '0, 4'd2, 8'd5, 0, 1));
        for (int i = 0; i < 13; i++)
            pending_items.push_back(build_item(ACT_WAIT, 32'h1 << i, i[3:0],
                                               (i % 3 == 0) ? 8'd7 : 8'(255 - i),
                                               i[0], i[1]));
        pending_items.push_back(build_item(ACT_WAIT, 32'h1, 4'd4, 8'd1, 0, 1));
        pending_items.push_back(build_item(ACT_SET, 32'h0000_0fff, '0, '0, 0, 0));
        pending_items.push_back(build_item(ACT_SET, '1, '0, '0, 0, 0));
        pending_items.push_back(build_item(ACT_READ, '1, '1, '1, 1, 1));
        total_items = pending_items.size();

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        wait_drained();

        // Random phases: three idling profiles, a long receiver stall in the first
        for (int ph = 0; ph < 3; ph++)
        begin
            send_idle_pct = (ph == 0) ? 19 : (ph == 1) ? 55 : 0;
            recv_idle_pct = (ph == 0) ? 55 : (ph == 1) ? 19 : 0;
            for (int n = 0; n < 170; n++)
            begin
                int pick;
                pick = $urandom_range(0, 9);
                if (pick < 5)
                    rq = build_item(ACT_WAIT, sparse_bits(), TASK_W'($urandom()),
                                    $urandom_range(0, 3) == 0
                                    ? 8'($urandom()) : 8'($urandom_range(0, 3)),
                                    1'($urandom()), 1'($urandom()));
                else if (pick < 8)
                    rq = build_item(ACT_SET, sparse_bits(), TASK_W'($urandom()),
                                    PRIO_W'($urandom()), 1'($urandom()), 1'($urandom()));
                else if (pick < 9)
                    rq = build_item(ACT_CLEAR, $urandom(), TASK_W'($urandom()),
                                    PRIO_W'($urandom()), 1'($urandom()), 1'($urandom()));
                else
                    rq = build_item(ACT_READ, $urandom(), TASK_W'($urandom()),
                                    PRIO_W'($urandom()), 1'($urandom()), 1'($urandom()));
                pending_items.push_back(rq);
            end
            total_items += 170;
            if (ph == 0)
                stall_go = 1'b1;
            wait_drained();
        end

        repeat (40) @(posedge clk);
        if (mismatches == 0 && expected_replies.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule

// ===== event_flag_group_waiters.f =====
rtl/core/egw_pkg.sv
rtl/core/egw_chan_if.sv
rtl/core/egw_ctrl.sv
rtl/core/egw_dp.sv
rtl/core/event_flag_group_waiters.sv
dv/tb_top.sv
